>>> design/tsc_pkg.sv
package tsc_pkg;

  localparam int POS_BITS      = 16;
  localparam int KEYWORD_CHARS = 6;
  localparam int WLEN_BITS     = $clog2(KEYWORD_CHARS + 2);
  localparam int WIDX_BITS     = $clog2(KEYWORD_CHARS);

  localparam int QDEPTH    = 4;
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);
  localparam int QIDX_BITS = $clog2(QDEPTH);

  localparam logic [4:0] K_SYMBOL  = 5'd0;
  localparam logic [4:0] K_FUNC    = 5'd1;
  localparam logic [4:0] K_NATIVE  = 5'd2;
  localparam logic [4:0] K_RETURN  = 5'd3;
  localparam logic [4:0] K_INT     = 5'd4;
  localparam logic [4:0] K_FLOAT   = 5'd5;
  localparam logic [4:0] K_STRING  = 5'd6;
  localparam logic [4:0] K_CHAR    = 5'd7;
  localparam logic [4:0] K_LPAREN  = 5'd8;
  localparam logic [4:0] K_RPAREN  = 5'd9;
  localparam logic [4:0] K_COMMA   = 5'd10;
  localparam logic [4:0] K_LBRACE  = 5'd11;
  localparam logic [4:0] K_RBRACE  = 5'd12;
  localparam logic [4:0] K_PLUS    = 5'd13;
  localparam logic [4:0] K_MINUS   = 5'd14;
  localparam logic [4:0] K_STAR    = 5'd15;
  localparam logic [4:0] K_EQEQ    = 5'd16;
  localparam logic [4:0] K_ASSIGN  = 5'd17;
  localparam logic [4:0] K_COLON   = 5'd18;
  localparam logic [4:0] K_SLASH   = 5'd19;
  localparam logic [4:0] K_ERROR   = 5'd20;

  localparam logic CFG_START_LINE   = 1'b0;
  localparam logic CFG_START_COLUMN = 1'b1;

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_COMMENT = 6'b000010,
    M_WORD    = 6'b000100,
    M_STRING  = 6'b001000,
    M_CHAR    = 6'b010000,
    M_NUMBER  = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [15:0] line_no;
    logic [15:0] column_no;
    logic        last;
  } result_t;

endpackage

>>> design/token_scanner.sv
// Channel | Dir | Handshake              | Payload
// in_     | in  | in_tvalid / in_tready  | in_tdata: char_code, next_char
// out_    | out | out_tvalid / out_tready| out_tdata: token fields, out_tlast: last_result
// cfg_    | in  | cfg_wr_en              | cfg_index, cfg_wdata
//
// One character per cycle while in_tready is high: each item is scanned in the cycle
// it is accepted and its zero, one or two tokens go into a four-deep result queue.
// in_tready is high while the queue holds two tokens or fewer, so items that give
// at most one token stream at one per cycle while the output is taken; the single
// output port sets the rate to one token per cycle. Results are registered in the queue.
// Synchronous active-low reset clears the scan state and the queue.
module token_scanner import tsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] char_code, [15:8] next_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [4:0] token_kind, [20:5] start_pos, [36:21] end_pos,
                                  // [52:37] line_no, [68:53] column_no, [71:69] zero
  output logic        out_tlast,  // last_result
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  mode_t                 mode_r, mode_nxt;
  logic [POS_BITS-1:0]   tstart_r, tstart_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [15:0]           line_r, line_nxt;
  logic [15:0]           col_r, col_nxt;
  logic [7:0]            prev_r, prev_nxt;
  logic                  dot_r, dot_nxt;
  logic [7:0]            wchars_r [KEYWORD_CHARS];
  logic [7:0]            wchars_nxt [KEYWORD_CHARS];
  logic [WLEN_BITS-1:0]  wlen_r, wlen_nxt;

  result_t               q_r [QDEPTH];
  result_t               q_nxt [QDEPTH];
  logic [QCNT_BITS-1:0]  cnt_r, cnt_nxt;

  logic [7:0]            c, nx;
  logic                  accept, pop;
  logic                  close_v, open_v, consumed, err;
  logic [4:0]            close_kind, open_kind;
  logic [POS_BITS-1:0]   pos_prev;
  mode_t                 mode_mid;
  result_t               res0, res1;
  logic [QCNT_BITS-1:0]  base;
  logic [4:0]            word_kind;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic logic [15:0] col_load(input logic [15:0] sc);
    return (sc != 16'd0) ? sc - 16'd1 : 16'd0;
  endfunction

  assign c        = in_tdata[7:0];
  assign nx       = in_tdata[15:8];
  assign accept   = in_tvalid && in_tready;
  assign pop      = out_tvalid && out_tready;
  assign pos_prev = pos_r - 1'b1;

  always_comb begin
    word_kind = K_SYMBOL;
    if (wlen_r == WLEN_BITS'(4) && wchars_r[0] == "f" && wchars_r[1] == "u" &&
        wchars_r[2] == "n" && wchars_r[3] == "c")
      word_kind = K_FUNC;
    else if (wlen_r == WLEN_BITS'(6) && wchars_r[0] == "n" && wchars_r[1] == "a" &&
             wchars_r[2] == "t" && wchars_r[3] == "i" && wchars_r[4] == "v" &&
             wchars_r[5] == "e")
      word_kind = K_NATIVE;
    else if (wlen_r == WLEN_BITS'(6) && wchars_r[0] == "r" && wchars_r[1] == "e" &&
             wchars_r[2] == "t" && wchars_r[3] == "u" && wchars_r[4] == "r" &&
             wchars_r[5] == "n")
      word_kind = K_RETURN;
  end

  // scan step for the item on the input
  always_comb begin
    line_nxt   = line_r;
    col_nxt    = col_r;
    mode_mid   = mode_r;
    dot_nxt    = dot_r;
    wchars_nxt = wchars_r;
    wlen_nxt   = wlen_r;
    tstart_nxt = tstart_r;
    close_v    = 1'b0;
    close_kind = K_SYMBOL;
    open_v     = 1'b0;
    open_kind  = K_SYMBOL;
    consumed   = 1'b0;
    err        = 1'b0;

    if (c == "\n") begin
      if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
      col_nxt = 16'd1;
    end else if (col_r != 16'hFFFF) begin
      col_nxt = col_r + 16'd1;
    end

    case (mode_r)
      M_COMMENT: begin
        if (c == "\n") mode_mid = M_IDLE;
      end
      M_NUMBER: begin
        if (dot_r) begin
          if (!is_digit(c)) begin
            close_v = 1'b1; close_kind = K_FLOAT; mode_mid = M_IDLE;
          end
        end else if (c == ".") begin
          dot_nxt = 1'b1;
        end else if (!is_digit(c)) begin
          close_v = 1'b1; close_kind = K_INT; mode_mid = M_IDLE;
        end
      end
      M_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (wlen_r < WLEN_BITS'(KEYWORD_CHARS)) wchars_nxt[wlen_r[WIDX_BITS-1:0]] = c;
          if (wlen_r < WLEN_BITS'(KEYWORD_CHARS + 1)) wlen_nxt = wlen_r + 1'b1;
        end else begin
          close_v = 1'b1; close_kind = word_kind; mode_mid = M_IDLE;
        end
      end
      M_STRING: begin
        if (c == "\"" && prev_r != "\\") begin
          close_v = 1'b1; close_kind = K_STRING; mode_mid = M_IDLE; consumed = 1'b1;
        end
      end
      M_CHAR: begin
        if (c == "'" && prev_r != "\\") begin
          close_v = 1'b1; close_kind = K_CHAR; mode_mid = M_IDLE; consumed = 1'b1;
        end
      end
      default: mode_mid = M_IDLE;
    endcase

    mode_nxt = mode_mid;
    if (mode_mid == M_IDLE && !consumed) begin
      tstart_nxt = pos_r;
      case (c)
        "'":  mode_nxt = M_CHAR;
        "\"": mode_nxt = M_STRING;
        "(":  begin open_v = 1'b1; open_kind = K_LPAREN; end
        ")":  begin open_v = 1'b1; open_kind = K_RPAREN; end
        ",":  begin open_v = 1'b1; open_kind = K_COMMA;  end
        "{":  begin open_v = 1'b1; open_kind = K_LBRACE; end
        "}":  begin open_v = 1'b1; open_kind = K_RBRACE; end
        "+":  begin open_v = 1'b1; open_kind = K_PLUS;   end
        "-":  begin open_v = 1'b1; open_kind = K_MINUS;  end
        "*":  begin open_v = 1'b1; open_kind = K_STAR;   end
        ":":  begin open_v = 1'b1; open_kind = K_COLON;  end
        "=": begin
          if (prev_r == "=") begin
            open_v = 1'b1; open_kind = K_EQEQ;
          end else if (nx != "=") begin
            open_v = 1'b1; open_kind = K_ASSIGN;
          end
        end
        "/": begin
          if (prev_r == "/") mode_nxt = M_COMMENT;
          else if (nx != "/") begin
            open_v = 1'b1; open_kind = K_SLASH;
          end
        end
        "\t", "\n", " ": ;
        default: begin
          if (is_alpha(c) || c == "_") begin
            mode_nxt      = M_WORD;
            wchars_nxt[0] = c;
            wlen_nxt      = WLEN_BITS'(1);
          end else if (is_digit(c)) begin
            mode_nxt = M_NUMBER;
            dot_nxt  = 1'b0;
          end else if (c == ".") begin
            mode_nxt = M_NUMBER;
            dot_nxt  = 1'b1;
          end else begin
            open_v = 1'b1; open_kind = K_ERROR; err = 1'b1;
          end
        end
      endcase
    end

    prev_nxt = err ? prev_r : c;
    pos_nxt  = pos_r + 1'b1;
  end

  // pack the results in order: closed token first, then the one this char starts
  always_comb begin
    result_t ropen, rclose;
    ropen.kind      = open_kind;
    ropen.start_pos = 16'(pos_r);
    ropen.end_pos   = 16'(pos_r);
    ropen.line_no   = line_nxt;
    ropen.column_no = col_nxt;
    ropen.last      = 1'b1;
    rclose.kind      = close_kind;
    rclose.start_pos = 16'(tstart_r);
    rclose.end_pos   = 16'(pos_prev);
    rclose.line_no   = line_nxt;
    rclose.column_no = col_nxt;
    rclose.last      = !open_v;
    res0 = close_v ? rclose : ropen;
    res1 = ropen;
  end

  // result queue: head at entry 0, shifts down on each pop
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    base    = cnt_r;
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) q_nxt[i] = q_r[i+1];
      base = cnt_r - 1'b1;
    end
    cnt_nxt = base;
    if (accept) begin
      if (close_v || open_v) q_nxt[base[QIDX_BITS-1:0]] = res0;
      if (close_v && open_v) q_nxt[base[QIDX_BITS-1:0] + 1'b1] = res1;
      cnt_nxt = base + QCNT_BITS'(close_v) + QCNT_BITS'(open_v);
    end
  end

  assign in_tready  = cnt_r <= QCNT_BITS'(QDEPTH - 2);
  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = {3'b000, q_r[0].column_no, q_r[0].line_no, q_r[0].end_pos,
                       q_r[0].start_pos, q_r[0].kind};
  assign out_tlast  = q_r[0].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      tstart_r <= '0;
      pos_r    <= '0;
      line_r   <= 16'd1;
      col_r    <= 16'd0;
      prev_r   <= 8'd0;
      dot_r    <= 1'b0;
      wlen_r   <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        mode_r   <= mode_nxt;
        tstart_r <= tstart_nxt;
        pos_r    <= pos_nxt;
        prev_r   <= prev_nxt;
        dot_r    <= dot_nxt;
        wlen_r   <= wlen_nxt;
      end
      // a register write also reloads its counter
      if (cfg_wr_en && cfg_index == CFG_START_LINE) line_r <= cfg_wdata;
      else if (accept) line_r <= line_nxt;
      if (cfg_wr_en && cfg_index == CFG_START_COLUMN) col_r <= col_load(cfg_wdata);
      else if (accept) col_r <= col_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (accept) wchars_r <= wchars_nxt;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> cnt_r <= QCNT_BITS'(QDEPTH - 2))
    else $error("item accepted with too little queue room");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !out_tlast |=> out_tvalid)
    else $error("second token of an item missing");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> pos_r == POS_BITS'($past(pos_r) + 1'b1))
    else $error("position did not advance by one");

  a_wlen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    wlen_r <= WLEN_BITS'(KEYWORD_CHARS + 1))
    else $error("word length beyond saturation");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_BITS'(QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tsc_pkg::*;

  localparam int LIMIT = 400000;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BSL = 8'h5C;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [15:0] in_tdata = '0;     // [7:0] char_code, [15:8] next_char
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [71:0] out_tdata;         // [4:0] kind, [20:5] start, [36:21] end, [52:37] line,
                                  // [68:53] column, [71:69] zero
  wire         out_tlast;         // last_result
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_START_LINE;
  logic [15:0] cfg_wdata = '0;

  token_scanner u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // scanner shadow state
  mode_t                scan_st;
  logic [15:0]          tok_begin;
  logic [15:0]          char_pos;
  logic [15:0]          line_ctr;
  logic [15:0]          col_ctr;
  logic [7:0]           last_ch;
  logic                 frac_seen;
  logic [7:0]           word_buf [KEYWORD_CHARS];
  logic [WLEN_BITS-1:0] word_cnt;

  result_t     tokens_due[$];
  logic [15:0] char_feed[$];
  logic [7:0]  text_buf[$];

  int   fed_count = 0;
  int   bad_count = 0;
  int   token_no = 0;
  int   cycle_no = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   in_gap = 0;
  int   out_wait = 0;
  bit   in_calm = 1'b0;
  bit   out_calm = 1'b0;
  bit   hold_arm = 1'b0;
  int   hold_left = 0;

  task automatic flag_error(input string msg);
    bad_count++;
    if (bad_count <= 40) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      flag_error($sformatf("token %0d %s: got %0d, want %0d", token_no, name, got, want));
  endtask

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [4:0] word_token();
    logic [31:0] w4;
    logic [47:0] w6;
    w4 = {word_buf[0], word_buf[1], word_buf[2], word_buf[3]};
    w6 = {w4, word_buf[4], word_buf[5]};
    if (word_cnt == 4 && w4 == "func") return K_FUNC;
    if (word_cnt == 6 && w6 == "native") return K_NATIVE;
    if (word_cnt == 6 && w6 == "return") return K_RETURN;
    return K_SYMBOL;
  endfunction

  function automatic result_t token_at(input logic [4:0] k, input logic [15:0] s,
                                       input logic [15:0] e);
    result_t r;
    r.kind = k;
    r.start_pos = s;
    r.end_pos = e;
    r.line_no = line_ctr;
    r.column_no = col_ctr;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic reset_scanner();
    scan_st = M_IDLE;
    tok_begin = '0;
    char_pos = '0;
    line_ctr = 16'd1;
    col_ctr = 16'd0;
    last_ch = '0;
    frac_seen = 1'b0;
    word_cnt = '0;
    for (int i = 0; i < KEYWORD_CHARS; i++) word_buf[i] = '0;
  endtask

  // Advance the shadow scanner by one character and queue the tokens it yields.
  function automatic void scan_char(input logic [7:0] c, input logic [7:0] nx);
    result_t     found[$];
    logic [15:0] prev_pos;
    bit          closed;
    bit          bad;
    closed = 1'b0;
    bad = 1'b0;
    prev_pos = char_pos - 16'd1;

    if (c == CH_NL) begin
      if (line_ctr != 16'hFFFF) line_ctr++;
      col_ctr = 16'd1;
    end else if (col_ctr != 16'hFFFF) begin
      col_ctr++;
    end

    case (scan_st)
      M_COMMENT: if (c == CH_NL) scan_st = M_IDLE;
      M_NUMBER: begin
        if (frac_seen) begin
          if (!is_digit(c)) begin
            found = {found, token_at(K_FLOAT, tok_begin, prev_pos)};
            scan_st = M_IDLE;
          end
        end else if (c == ".") begin
          frac_seen = 1'b1;
        end else if (!is_digit(c)) begin
          found = {found, token_at(K_INT, tok_begin, prev_pos)};
          scan_st = M_IDLE;
        end
      end
      M_WORD: begin
        if (is_letter(c) || is_digit(c)) begin
          if (word_cnt < KEYWORD_CHARS) word_buf[word_cnt] = c;
          if (word_cnt < KEYWORD_CHARS + 1) word_cnt++;
        end else begin
          found = {found, token_at(word_token(), tok_begin, prev_pos)};
          scan_st = M_IDLE;
        end
      end
      M_STRING: begin
        if (c == CH_DQ && last_ch != CH_BSL) begin
          found = {found, token_at(K_STRING, tok_begin, prev_pos)};
          scan_st = M_IDLE;
          closed = 1'b1;
        end
      end
      M_CHAR: begin
        if (c == CH_SQ && last_ch != CH_BSL) begin
          found = {found, token_at(K_CHAR, tok_begin, prev_pos)};
          scan_st = M_IDLE;
          closed = 1'b1;
        end
      end
      default: scan_st = M_IDLE;
    endcase

    if (scan_st == M_IDLE && !closed) begin
      tok_begin = char_pos;
      case (c)
        CH_SQ: scan_st = M_CHAR;
        CH_DQ: scan_st = M_STRING;
        "(": found = {found, token_at(K_LPAREN, char_pos, char_pos)};
        ")": found = {found, token_at(K_RPAREN, char_pos, char_pos)};
        ",": found = {found, token_at(K_COMMA, char_pos, char_pos)};
        "{": found = {found, token_at(K_LBRACE, char_pos, char_pos)};
        "}": found = {found, token_at(K_RBRACE, char_pos, char_pos)};
        "+": found = {found, token_at(K_PLUS, char_pos, char_pos)};
        "-": found = {found, token_at(K_MINUS, char_pos, char_pos)};
        "*": found = {found, token_at(K_STAR, char_pos, char_pos)};
        ":": found = {found, token_at(K_COLON, char_pos, char_pos)};
        "=": begin
          if (last_ch == "=") found = {found, token_at(K_EQEQ, char_pos, char_pos)};
          else if (nx != "=") found = {found, token_at(K_ASSIGN, char_pos, char_pos)};
        end
        "/": begin
          if (last_ch == "/") scan_st = M_COMMENT;
          else if (nx != "/") found = {found, token_at(K_SLASH, char_pos, char_pos)};
        end
        CH_TAB, CH_NL, " ": ;
        default: begin
          if (is_letter(c) || c == "_") begin
            scan_st = M_WORD;
            word_buf[0] = c;
            word_cnt = 1;
          end else if (is_digit(c)) begin
            scan_st = M_NUMBER;
            frac_seen = 1'b0;
          end else if (c == ".") begin
            scan_st = M_NUMBER;
            frac_seen = 1'b1;
          end else begin
            found = {found, token_at(K_ERROR, char_pos, char_pos)};
            bad = 1'b1;
          end
        end
      endcase
    end

    // an erroring byte leaves the previous character alone
    if (!bad) last_ch = c;
    char_pos++;
    if (found.size() != 0) found[found.size() - 1].last = 1'b1;
    tokens_due = {tokens_due, found};
  endfunction

  // ---------------- stimulus helpers ----------------

  task automatic push_item(input logic [7:0] c, input logic [7:0] nx);
    logic [15:0] w;
    w = {nx, c};
    char_feed = {char_feed, w};
    fed_count++;
  endtask

  task automatic put_ch(input logic [7:0] ch);
    text_buf = {text_buf, ch};
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endtask

  // text goes out with its real lookahead; the last char sees end of text
  task automatic flush_text();
    for (int i = 0; i < text_buf.size(); i++)
      push_item(text_buf[i], (i + 1 < text_buf.size()) ? text_buf[i + 1] : 8'h00);
    text_buf.delete();
  endtask

  function automatic logic [7:0] any_letter();
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] body_char();
    case ($urandom_range(0, 9))
      0: return CH_BSL;
      1: return CH_NL;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic gen_token();
    string ops;
    ops = "(),{}+-*:=/";
    case ($urandom_range(0, 11))
      0: case ($urandom_range(0, 2))
        0: add_str("func");
        1: add_str("native");
        default: add_str("return");
      endcase
      1: begin
        case ($urandom_range(0, 7))
          0: add_str("funcs");
          1: add_str("nativ");
          2: add_str("returns");
          default: begin
            put_ch($urandom_range(0, 4) == 0 ? 8'h5F : any_letter());
            repeat ($urandom_range(0, 8))
              put_ch($urandom_range(0, 3) == 0 ? any_digit() : any_letter());
          end
        endcase
      end
      2: repeat ($urandom_range(1, 4)) put_ch(any_digit());
      3: begin
        if ($urandom_range(0, 3) != 0)
          repeat ($urandom_range(1, 3)) put_ch(any_digit());
        put_ch(".");
        repeat ($urandom_range(0, 3)) put_ch(any_digit());
      end
      4: begin
        put_ch(CH_DQ);
        repeat ($urandom_range(0, 6)) put_ch(body_char());
        put_ch(CH_DQ);
      end
      5: begin
        put_ch(CH_SQ);
        if ($urandom_range(0, 3) == 0) put_ch(CH_BSL);
        put_ch(body_char());
        put_ch(CH_SQ);
      end
      6, 7: put_ch(ops[$urandom_range(0, ops.len() - 1)]);
      8: add_str("==");
      9: begin
        add_str("//");
        repeat ($urandom_range(0, 8)) put_ch(8'($urandom_range(32, 126)));
        put_ch(CH_NL);
      end
      10: put_ch(CH_NL);
      default: case ($urandom_range(0, 4))
        0: put_ch(8'h00);
        1: put_ch(8'h0D);
        2: put_ch("@");
        3: put_ch(";");
        default: put_ch(8'h80 + 8'($urandom_range(0, 127)));
      endcase
    endcase
    // adjacent tokens exercise the close-and-open pair of results
    case ($urandom_range(0, 5))
      2: put_ch(" ");
      3: put_ch(CH_TAB);
      4: put_ch(CH_NL);
      5: add_str("  ");
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_START_LINE) begin
      line_ctr = val;
    end else begin
      col_ctr = (val != 0) ? val - 16'd1 : 16'd0;
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (char_feed.size() != 0 || in_tvalid || tokens_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // ---------------- sequencing ----------------

  initial begin
    int          base;
    logic [15:0] lv;
    logic [15:0] cv;
    reset_scanner();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: operators, keyword, float, escaped string, char, byte extremes
    add_str("func(a,1.5){x==y/\"s\\\"\" 'c'}");
    flush_text();
    push_item(8'h00, 8'hFF);
    push_item(8'hFF, 8'h00);
    push_item(8'h80, 8'h7F);
    push_item(8'h0D, 8'h0A);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin lv = 16'd0;     cv = 16'd0;     end
        1: begin lv = 16'hFFFF;  cv = 16'hFFFF;  end
        2: begin lv = 16'd65533; cv = 16'd65530; end
        3: begin lv = 16'($urandom); cv = 16'($urandom); end
        default: begin lv = 16'd1; cv = 16'd1; end
      endcase
      write_reg(CFG_START_LINE, lv);
      write_reg(CFG_START_COLUMN, cv);
      if (ph == 2) begin
        @(posedge clk);
        hold_arm = 1'b1;
      end
      base = fed_count;
      while (fed_count - base < 175) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 5)) push_item(8'($urandom), 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 6)) gen_token();
          flush_text();
        end
      end
      wait_idle();
    end

    // closing text under freshly loaded line and column
    write_reg(CFG_START_LINE, 16'd10);
    write_reg(CFG_START_COLUMN, 16'd2000);
    put_ch(" ");
    case (scan_st)
      M_STRING:  put_ch(CH_DQ);
      M_CHAR:    put_ch(CH_SQ);
      M_COMMENT: put_ch(CH_NL);
      default:   put_ch(" ");
    endcase
    add_str("abcd=12.5/\"q\"\n;x");
    flush_text();
    wait_idle();

    repeat (20) @(posedge clk);
    if (bad_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // ---------------- sender ----------------

  always @(negedge clk) begin : feed
    logic        offer;
    logic [15:0] word;
    offer = in_tvalid;
    word = in_tdata;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (in_tvalid && in_taken) begin
        offer = 1'b0;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 10);
      end
      if (!offer) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (char_feed.size() != 0) begin
          word = char_feed.pop_front();
          offer = 1'b1;
        end
      end
    end
    in_tvalid <= offer;
    in_tdata <= word;
  end

  // ---------------- receiver ----------------

  always @(negedge clk) begin : hold_off
    if (hold_arm) begin
      hold_left <= 300;
      hold_arm = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin : drain
    if (out_taken) begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      out_wait = out_calm ? 0 : $urandom_range(0, 10);
    end
    out_tready <= rst_n && out_wait == 0 && hold_left == 0;
    if (out_wait != 0) out_wait--;
  end

  // ---------------- checking ----------------

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    out_taken <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tdata[4:0];
      got.start_pos = out_tdata[20:5];
      got.end_pos = out_tdata[36:21];
      got.line_no = out_tdata[52:37];
      got.column_no = out_tdata[68:53];
      got.last = out_tlast;
      if (tokens_due.size() == 0) begin
        flag_error($sformatf("token %0d arrived with none expected (kind %0d)",
                             token_no, got.kind));
      end else begin
        want = tokens_due.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("start_pos", got.start_pos, want.start_pos);
        check_field("end_pos", got.end_pos, want.end_pos);
        check_field("line_no", got.line_no, want.line_no);
        check_field("column_no", got.column_no, want.column_no);
        check_field("last", got.last, want.last);
      end
      token_no++;
    end
    if (rst_n && in_tvalid && in_tready) scan_char(in_tdata[7:0], in_tdata[15:8]);
  end

  always @(posedge clk) begin : watchdog
    cycle_no++;
    if (cycle_no == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
